@@ hdl/arx_pkg.sv @@
package arx_pkg;

	// fixed field widths
	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 16;
	localparam int COEF_FRAC     = 12;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int DELAY_FIELD_W = 4;

	// coefficients reachable through the register map
	localparam int NUM_A_REGS = 3;
	localparam int NUM_B_REGS = 3;

	// parameter defaults
	localparam int ORDER_A_DEF   = 3;
	localparam int ORDER_B_DEF   = 3;
	localparam int MAX_DELAY_DEF = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A1 = 3'd0,
		REG_COEF_A2 = 3'd1,
		REG_COEF_A3 = 3'd2,
		REG_COEF_B0 = 3'd3,
		REG_COEF_B1 = 3'd4,
		REG_COEF_B2 = 3'd5,
		REG_DELAY   = 3'd6
	} arx_reg_t;

	// per-cell control
	typedef struct packed {
		logic start;   // capture coef * tap
		logic shift;   // take neighbour's tap
	} arx_cell_ctl_t;

endpackage

@@ hdl/arx_if.sv @@
interface arx_in_if #(
	parameter int SAMPLE_WIDTH = arx_pkg::SAMPLE_W
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface arx_out_if #(
	parameter int SAMPLE_WIDTH = arx_pkg::SAMPLE_W
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

interface arx_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [arx_pkg::CFG_IDX_W-1:0]      index;
	logic [arx_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/arx_tap_cell.sv @@
module arx_tap_cell #(
	parameter int SAMPLE_WIDTH = arx_pkg::SAMPLE_W,
	parameter int ACC_W        = 2 * arx_pkg::SAMPLE_W + 4,
	parameter bit SUBTRACT     = 1'b0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  arx_pkg::arx_cell_ctl_t                ctl,
	input  logic signed [arx_pkg::COEF_W-1:0]     coef,
	input  logic signed [SAMPLE_WIDTH-1:0]        tap_in,
	output logic signed [SAMPLE_WIDTH-1:0]        tap_out,
	input  logic                                  link_vld_in,
	input  logic signed [ACC_W-1:0]               link_sum_in,
	output logic                                  link_vld_out,
	output logic signed [ACC_W-1:0]               link_sum_out
);
	import arx_pkg::*;

	localparam int PROD_W = COEF_W + SAMPLE_WIDTH;

	logic signed [SAMPLE_WIDTH-1:0] tap_q;
	logic signed [PROD_W-1:0]       prod_s1;
	logic signed [ACC_W-1:0]        sum_s2;
	logic                           vld_q;
	logic signed [ACC_W-1:0]        prod_ext;

	// held sample, shifted along the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (ctl.shift) begin
			tap_q <= tap_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			prod_s1 <= coef * tap_q;
		end
	end

	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk) begin
		if (link_vld_in) begin
			sum_s2 <= SUBTRACT ? (link_sum_in - prod_ext) : (link_sum_in + prod_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= link_vld_in;
		end
	end

	assign tap_out      = tap_q;
	assign link_vld_out = vld_q;
	assign link_sum_out = sum_s2;

endmodule

@@ hdl/arx_delay_line.sv @@
module arx_delay_line #(
	parameter int SAMPLE_WIDTH = arx_pkg::SAMPLE_W,
	parameter int MAX_DELAY    = arx_pkg::MAX_DELAY_DEF,
	parameter int DLY_W        = $clog2(MAX_DELAY + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic [DLY_W-1:0]               delay,
	output logic signed [SAMPLE_WIDTH-1:0] newest
);
	import arx_pkg::*;

	localparam int DL_DEPTH = (MAX_DELAY > 1) ? MAX_DELAY - 1 : 1;
	localparam int DL_IW    = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;

	logic signed [SAMPLE_WIDTH-1:0] line_q [DL_DEPTH];
	logic [DLY_W-1:0]               dly_m2;
	logic [DL_IW-1:0]               rd_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL_DEPTH; i++) begin
				line_q[i] <= '0;
			end
		end else if (shift) begin
			line_q[0] <= sample;
			for (int i = 1; i < DL_DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	// sample leaving the transport delay, u(k-d+1)
	assign dly_m2 = delay - DLY_W'(2);
	assign rd_idx = dly_m2[DL_IW-1:0];

	always_comb begin
		if (delay <= DLY_W'(1)) begin
			newest = sample;
		end else begin
			newest = line_q[rd_idx];
		end
	end

endmodule

@@ hdl/arx_model_simulator.sv @@
// arx plant model: y(k) = sum b(i)*u(k-d-i) - sum a(i)*y(k-1-i), rounded and saturated
// path: the accepted input is registered, the partial sum then passes each cell in turn, then the output register
// a new item is taken only once the previous y has reached the output taps, set by the partial sum
//   walking the cell row and the feedback of y(k) into the output taps
// reset: taps and delay line cleared, coefficients zero, transport delay one
module arx_model_simulator #(
	parameter int ORDER_A      = arx_pkg::ORDER_A_DEF,
	parameter int ORDER_B      = arx_pkg::ORDER_B_DEF,
	parameter int MAX_DELAY    = arx_pkg::MAX_DELAY_DEF,
	parameter int SAMPLE_WIDTH = arx_pkg::SAMPLE_W
) (
	input  logic      clk,
	input  logic      arst_n,
	arx_in_if.sink    din,
	arx_out_if.source dout,
	arx_cfg_if.sink   cfg
);
	import arx_pkg::*;

	localparam int N_CELLS = ORDER_A + ORDER_B;
	localparam int ACC_W   = COEF_W + SAMPLE_WIDTH + $clog2(N_CELLS) + 1;
	localparam int DLY_W   = $clog2(MAX_DELAY + 1);

	// saturation bounds at accumulator width
	localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SAMPLE_WIDTH+1){1'b0}},
		{(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC - 1);

	// handshake and sequencing
	logic in_acc;
	logic out_free;
	logic busy_q;
	logic start_q;
	logic pend_q;
	logic out_vld_q;
	logic y_we;

	// configuration
	logic [DLY_W-1:0]         delay_q;
	logic [DLY_W-1:0]         delay_clamped;
	logic [DELAY_FIELD_W-1:0] delay_field;
	logic                     cfg_we;

	// data path
	logic signed [SAMPLE_WIDTH-1:0] newest;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                           y_clip;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic                           sat_q;
	logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                           out_sat_q;

	// cell row
	logic                           vld_chain [N_CELLS+1];
	logic signed [ACC_W-1:0]        sum_chain [N_CELLS+1];
	logic signed [SAMPLE_WIDTH-1:0] tap_b     [ORDER_B];
	logic signed [SAMPLE_WIDTH-1:0] tap_a     [ORDER_A];
	logic signed [COEF_W-1:0]       coef_b    [ORDER_B];
	logic signed [COEF_W-1:0]       coef_a    [ORDER_A];
	arx_cell_ctl_t                  ctl_b;
	arx_cell_ctl_t                  ctl_a;

	// ---------------------------------------------------------------
	// configuration port, always ready
	// ---------------------------------------------------------------
	assign cfg.ready   = 1'b1;
	assign cfg_we      = cfg.valid;
	assign delay_field = cfg.data[DELAY_FIELD_W-1:0];

	// delay of zero becomes one, above the line length becomes the maximum
	always_comb begin
		if (delay_field == '0) begin
			delay_clamped = DLY_W'(1);
		end else if (int'(delay_field) > MAX_DELAY) begin
			delay_clamped = DLY_W'(MAX_DELAY);
		end else begin
			delay_clamped = DLY_W'(delay_field);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DLY_W'(1);
		end else if (cfg_we && cfg.index == REG_DELAY) begin
			delay_q <= delay_clamped;
		end
	end

	// coefficient registers; taps beyond the register map keep a zero weight
	for (genvar i = 0; i < ORDER_A; i++) begin : g_coef_a
		if (i < NUM_A_REGS) begin : g_reg
			logic signed [COEF_W-1:0] coef_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					coef_q <= '0;
				end else if (cfg_we && cfg.index == REG_COEF_A1 + CFG_IDX_W'(i)) begin
					coef_q <= cfg.data;
				end
			end
			assign coef_a[i] = coef_q;
		end else begin : g_zero
			assign coef_a[i] = '0;
		end
	end

	for (genvar i = 0; i < ORDER_B; i++) begin : g_coef_b
		if (i < NUM_B_REGS) begin : g_reg
			logic signed [COEF_W-1:0] coef_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					coef_q <= '0;
				end else if (cfg_we && cfg.index == REG_COEF_B0 + CFG_IDX_W'(i)) begin
					coef_q <= cfg.data;
				end
			end
			assign coef_b[i] = coef_q;
		end else begin : g_zero
			assign coef_b[i] = '0;
		end
	end

	// ---------------------------------------------------------------
	// input side: a new item may enter as soon as the previous y has
	// reached the output taps and is leaving for the output register
	// ---------------------------------------------------------------
	assign out_free  = !out_vld_q || dout.ready;
	assign din.ready = !busy_q || (pend_q && out_free);
	assign in_acc    = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= in_acc;
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (pend_q && out_free) begin
				busy_q <= 1'b0;
			end
		end
	end

	// transport delay line feeds the first input tap
	arx_delay_line #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.MAX_DELAY    (MAX_DELAY),
		.DLY_W        (DLY_W)
	) u_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (in_acc),
		.sample (din.sample_in),
		.delay  (delay_q),
		.newest (newest)
	);

	// ---------------------------------------------------------------
	// cell row: b cells first, then a cells; every cell grabs its
	// product at accept, the partial sum then hops one cell per cycle
	// ---------------------------------------------------------------
	assign ctl_b.start = in_acc;
	assign ctl_b.shift = in_acc;
	assign ctl_a.start = in_acc;
	assign ctl_a.shift = y_we;

	assign vld_chain[0] = start_q;
	assign sum_chain[0] = '0;

	for (genvar i = 0; i < ORDER_B; i++) begin : g_bcell
		arx_tap_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.ACC_W        (ACC_W),
			.SUBTRACT     (1'b0)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl_b),
			.coef         (coef_b[i]),
			.tap_in       ((i == 0) ? newest : tap_b[(i == 0) ? 0 : i-1]),
			.tap_out      (tap_b[i]),
			.link_vld_in  (vld_chain[i]),
			.link_sum_in  (sum_chain[i]),
			.link_vld_out (vld_chain[i+1]),
			.link_sum_out (sum_chain[i+1])
		);
	end

	for (genvar j = 0; j < ORDER_A; j++) begin : g_acell
		arx_tap_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.ACC_W        (ACC_W),
			.SUBTRACT     (1'b1)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl_a),
			.coef         (coef_a[j]),
			.tap_in       ((j == 0) ? y_sat : tap_a[(j == 0) ? 0 : j-1]),
			.tap_out      (tap_a[j]),
			.link_vld_in  (vld_chain[ORDER_B+j]),
			.link_sum_in  (sum_chain[ORDER_B+j]),
			.link_vld_out (vld_chain[ORDER_B+j+1]),
			.link_sum_out (sum_chain[ORDER_B+j+1])
		);
	end

	// ---------------------------------------------------------------
	// round half up, drop the fraction, clip to the sample range
	// ---------------------------------------------------------------
	always_comb begin
		logic signed [ACC_W-1:0] rnd;
		logic signed [ACC_W-1:0] whole;
		rnd   = sum_chain[N_CELLS] + HALF;
		whole = rnd >>> COEF_FRAC;
		if (whole > SMAX) begin
			y_sat  = SMAX[SAMPLE_WIDTH-1:0];
			y_clip = 1'b1;
		end else if (whole < SMIN) begin
			y_sat  = SMIN[SAMPLE_WIDTH-1:0];
			y_clip = 1'b1;
		end else begin
			y_sat  = whole[SAMPLE_WIDTH-1:0];
			y_clip = 1'b0;
		end
	end

	// end of the row: y goes into the output taps and waits for the output register
	assign y_we = vld_chain[N_CELLS];

	always_ff @(posedge clk) begin
		if (y_we) begin
			y_q   <= y_sat;
			sat_q <= y_clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (y_we) begin
			pend_q <= 1'b1;
		end else if (out_free) begin
			pend_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pend_q && out_free) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && out_free) begin
			out_sample_q <= y_q;
			out_sat_q    <= sat_q;
		end
	end

	assign dout.valid      = out_vld_q;
	assign dout.sample_out = out_sample_q;
	assign dout.saturated  = out_sat_q;

endmodule
